// File: sv/pcm_ffr_pkg.sv
// ----------------------------------------------------------------------------
// PCM frame format remap package
// Shared types and codes for the sample format converter and its lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package pcm_ffr_pkg;

  // Sample kinds, taken from the low two bits of a format code.
  localparam logic [1:0] FMT_S16 = 2'd0;
  localparam logic [1:0] FMT_S32 = 2'd1;
  localparam logic [1:0] FMT_F32 = 2'd2;
  localparam logic [1:0] FMT_F64 = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_IN_FMT   = 3'd0;
  localparam logic [2:0] REG_OUT_FMT  = 3'd1;
  localparam logic [2:0] REG_IN_CNT   = 3'd2;
  localparam logic [2:0] REG_OUT_CNT  = 3'd3;
  localparam logic [2:0] REG_REMAP    = 3'd4;

  localparam int unsigned NUM_CH = 8;

  typedef struct packed {
    logic [2:0]  ifmt;
    logic [2:0]  ofmt;
    logic [3:0]  icnt;
    logic [3:0]  ocnt;
    logic [31:0] remap;
  } cfg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

endpackage

`default_nettype wire

// File: sv/pcm_frame_format_remap.sv
// ----------------------------------------------------------------------------
// PCM frame format remap
// Converts one frame of eight sample words per beat, with channel remap.
// ----------------------------------------------------------------------------
// Input and output are valid/ready channels; each beat carries a whole frame
// of eight sample words plus a last-frame mark. Every output channel has its
// own conversion lane, and the lane results are merged into one output
// register. The pipeline has three lane stages and the output register. One
// frame is taken every cycle while the pipeline has a free stage; the rate
// is set by the lane pipeline, which advances each stage whenever the stage
// after it is free.
// When the receiver stalls, frames pile up in the empty stages; input ready
// falls only once all four stages hold a frame.
// The configuration port writes a register at each edge with cfg_we_i high;
// change it only while no frame is in flight.
// Reset empties the pipeline and loads the default configuration: 16-bit
// in and out, two channels each, identity channel map.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_frame_format_remap
  import pcm_ffr_pkg::*;
#(
  parameter int unsigned CHANNELS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] in_ch0_i,
  input  wire logic [63:0] in_ch1_i,
  input  wire logic [63:0] in_ch2_i,
  input  wire logic [63:0] in_ch3_i,
  input  wire logic [63:0] in_ch4_i,
  input  wire logic [63:0] in_ch5_i,
  input  wire logic [63:0] in_ch6_i,
  input  wire logic [63:0] in_ch7_i,
  input  wire logic        in_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      out_ch0_o,
  output logic [63:0]      out_ch1_o,
  output logic [63:0]      out_ch2_o,
  output logic [63:0]      out_ch3_o,
  output logic [63:0]      out_ch4_o,
  output logic [63:0]      out_ch5_o,
  output logic [63:0]      out_ch6_o,
  output logic [63:0]      out_ch7_o,
  output logic             out_last_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ifmt  <= 3'd0;
      cfg_q.ofmt  <= 3'd0;
      cfg_q.icnt  <= 4'd2;
      cfg_q.ocnt  <= 4'd2;
      cfg_q.remap <= 32'h7654_3210;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IN_FMT:  cfg_q.ifmt  <= cfg_data_i[2:0];
        REG_OUT_FMT: cfg_q.ofmt  <= cfg_data_i[2:0];
        REG_IN_CNT:  cfg_q.icnt  <= cfg_data_i[3:0];
        REG_OUT_CNT: cfg_q.ocnt  <= cfg_data_i[3:0];
        REG_REMAP:   cfg_q.remap <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline control: each stage moves when the stage after it is free.
  logic     v1_q, v2_q, v3_q, vo_q;
  logic     last1_q, last2_q, last3_q, lasto_q;
  logic     en_out;
  pipe_en_t en;

  assign en_out = !vo_q || out_ready_i;
  assign en.s3  = !v3_q || en_out;
  assign en.s2  = !v2_q || en.s3;
  assign en.s1  = !v1_q || en.s2;
  assign in_ready_o = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en.s1)  v1_q <= in_valid_i;
      if (en.s2)  v2_q <= v1_q;
      if (en.s3)  v3_q <= v2_q;
      if (en_out) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1)  last1_q <= in_last_i;
    if (en.s2)  last2_q <= last1_q;
    if (en.s3)  last3_q <= last2_q;
    if (en_out) lasto_q <= last3_q;
  end

  logic [NUM_CH-1:0][63:0] in_w, res_w, out_q;

  assign in_w = {in_ch7_i, in_ch6_i, in_ch5_i, in_ch4_i,
                 in_ch3_i, in_ch2_i, in_ch1_i, in_ch0_i};

  for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
    if (k < CHANNELS) begin : g_on
      pcm_ffr_lane #(
        .Idx      (k),
        .Channels (CHANNELS)
      ) u_lane (
        .clk_i (clk_i),
        .en_i  (en),
        .cfg_i (cfg_q),
        .in_i  (in_w),
        .res_o (res_w[k])
      );
    end else begin : g_off
      assign res_w[k] = '0;
    end
  end

  // Merge the lane results into the output beat.
  always_ff @(posedge clk_i) begin
    if (en_out) out_q <= res_w;
  end

  assign out_valid_o = vo_q;
  assign out_last_o  = lasto_q;
  assign out_ch0_o   = out_q[0];
  assign out_ch1_o   = out_q[1];
  assign out_ch2_o   = out_q[2];
  assign out_ch3_o   = out_q[3];
  assign out_ch4_o   = out_q[4];
  assign out_ch5_o   = out_q[5];
  assign out_ch6_o   = out_q[6];
  assign out_ch7_o   = out_q[7];

endmodule

`default_nettype wire

// File: sv/pcm_ffr_lane.sv
// ----------------------------------------------------------------------------
// PCM frame format remap lane
// Selects one source channel and converts its sample in three stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pcm_ffr_lane
  import pcm_ffr_pkg::*;
#(
  parameter int unsigned Idx      = 0,
  parameter int unsigned Channels = 8
) (
  input  wire logic                     clk_i,
  input  wire pipe_en_t                 en_i,
  input  wire cfg_t                     cfg_i,
  input  wire logic [NUM_CH-1:0][63:0]  in_i,
  output logic [63:0]                   res_o
);

  localparam logic [3:0] LaneNum = 4'(Idx);
  localparam logic [3:0] NumCh   = 4'(Channels);

  function automatic logic [4:0] msb_pos(input logic [31:0] x);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  logic [1:0] ik, ok;
  assign ik = cfg_i.ifmt[1:0];
  assign ok = cfg_i.ofmt[1:0];

  // Stage 1: source select.
  logic [3:0]  src;
  logic        live;
  logic [63:0] raw1_q;
  logic        live1_q;

  assign src  = cfg_i.remap[4*Idx +: 4];
  assign live = (LaneNum < cfg_i.ocnt) && !src[3] && (src < NumCh) && (src < cfg_i.icnt);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      raw1_q  <= in_i[src[2:0]];
      live1_q <= live;
    end
  end

  // Stage 2: unpack to sign, exponent and 53-bit mantissa, then clamp to one.
  logic [31:0]        sx, nsrc;
  logic [4:0]         p;
  logic [52:0]        mn, m2_d;
  logic signed [12:0] e2_d;
  logic               sg2_d, nan2_d, inf2_d, big;
  logic [63:0]        raw2_q;
  logic [52:0]        m2_q;
  logic signed [12:0] e2_q;
  logic               sg2_q, nan2_q, live2_q;

  always_comb begin
    sx     = (ik == FMT_S16) ? {{16{raw1_q[15]}}, raw1_q[15:0]} : raw1_q[31:0];
    nsrc   = (ik == FMT_F32) ? {9'b0, raw1_q[22:0]} : (sx[31] ? (~sx + 32'd1) : sx);
    p      = msb_pos(nsrc);
    mn     = 53'(nsrc) << (6'd52 - {1'b0, p});
    m2_d   = mn;
    e2_d   = '0;
    sg2_d  = 1'b0;
    nan2_d = 1'b0;
    inf2_d = 1'b0;
    case (ik)
      FMT_S16: begin
        sg2_d = raw1_q[15];
        e2_d  = $signed({8'b0, p}) - 13'sd15;
      end
      FMT_S32: begin
        sg2_d = raw1_q[31];
        e2_d  = $signed({8'b0, p}) - 13'sd31;
      end
      FMT_F32: begin
        sg2_d = raw1_q[31];
        if (raw1_q[30:23] == 8'hFF) begin
          m2_d   = '0;
          nan2_d = (raw1_q[22:0] != '0);
          inf2_d = (raw1_q[22:0] == '0);
        end else if (raw1_q[30:23] == 8'h00) begin
          e2_d = $signed({8'b0, p}) - 13'sd149;
        end else begin
          m2_d = {1'b1, raw1_q[22:0], 29'b0};
          e2_d = $signed({5'b0, raw1_q[30:23]}) - 13'sd127;
        end
      end
      default: begin
        sg2_d = raw1_q[63];
        if (raw1_q[62:52] == 11'h7FF) begin
          m2_d   = '0;
          nan2_d = (raw1_q[51:0] != '0);
          inf2_d = (raw1_q[51:0] == '0);
        end else if (raw1_q[62:52] == 11'h000) begin
          m2_d = {1'b0, raw1_q[51:0]};
          e2_d = -13'sd1022;
        end else begin
          m2_d = {1'b1, raw1_q[51:0]};
          e2_d = $signed({2'b0, raw1_q[62:52]}) - 13'sd1023;
        end
      end
    endcase
    big = inf2_d || ((m2_d != '0) && !nan2_d &&
          ((e2_d > 13'sd0) || ((e2_d == 13'sd0) && (m2_d[51:0] != '0))));
    if (big) begin
      m2_d = 53'(1) << 52;
      e2_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      raw2_q  <= raw1_q;
      m2_q    <= m2_d;
      e2_q    <= e2_d;
      sg2_q   <= sg2_d;
      nan2_q  <= nan2_d;
      live2_q <= live1_q;
    end
  end

  // Stage 3: direct results, exact integer product, float alignment.
  logic [63:0]        copy_v, nan_v, dbl_v, dres_d;
  logic [51:0]        nmant;
  logic               nsign, direct_d;
  logic [4:0]         kk;
  logic [83:0]        q_d;
  logic               ge;
  logic signed [12:0] diff;
  logic [5:0]         fsh;
  logic [116:0]       ext;
  logic [63:0]        dres3_q;
  logic [83:0]        q3_q;
  logic signed [12:0] e3_q;
  logic               direct3_q, tiny3_q, sg3_q, fr3_q, fs3_q, live3_q;
  logic [23:0]        fm3_q;
  logic [7:0]         fbase3_q;

  assign kk = (ok == FMT_S16) ? 5'd15 : 5'd31;

  always_comb begin
    case (ik)
      FMT_S16: copy_v = {48'b0, raw2_q[15:0]};
      FMT_S32: copy_v = {32'b0, raw2_q[31:0]};
      FMT_F32: copy_v = {32'b0, raw2_q[31:0]};
      default: copy_v = raw2_q;
    endcase
    if (ik == FMT_F32) begin
      nsign = raw2_q[31];
      nmant = {raw2_q[22:0], 29'b0};
    end else begin
      nsign = raw2_q[63];
      nmant = raw2_q[51:0];
    end
    // A NaN is made quiet unless it passes from double to double.
    if (!((ik == FMT_F64) && (ok == FMT_F64))) nmant[51] = 1'b1;
    if (!ok[1])             nan_v = '0;
    else if (ok == FMT_F32) nan_v = {32'b0, nsign, 8'hFF, nmant[51:29]};
    else                    nan_v = {nsign, 11'h7FF, nmant};
    dbl_v = {sg2_q, (m2_q[52] ? 11'(e2_q + 13'sd1023) : 11'h000), m2_q[51:0]};
    direct_d = (cfg_i.ifmt == cfg_i.ofmt) || nan2_q || (ok == FMT_F64);
    if (cfg_i.ifmt == cfg_i.ofmt) dres_d = copy_v;
    else if (nan2_q)              dres_d = nan_v;
    else                          dres_d = dbl_v;
    // Scale by 2^k - 1 as a shift and a subtract.
    q_d  = ({31'b0, m2_q} << kk) - {31'b0, m2_q};
    ge   = (e2_q >= -13'sd126);
    diff = -13'sd126 - e2_q;
    if (ge)                    fsh = 6'd29;
    else if (diff > 13'sd34)   fsh = 6'd63;
    else                       fsh = 6'(13'sd29 + diff);
    ext = {m2_q, 64'b0} >> fsh;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      direct3_q <= direct_d;
      dres3_q   <= dres_d;
      q3_q      <= q_d;
      e3_q      <= e2_q;
      tiny3_q   <= (e2_q < -13'sd40);
      sg3_q     <= sg2_q;
      fm3_q     <= ext[87:64];
      fr3_q     <= ext[63];
      fs3_q     <= |ext[62:0];
      // A zero sample has no leading one and keeps a zero exponent.
      fbase3_q  <= (ge && m2_q[52]) ? 8'(e2_q + 13'sd126) : 8'h00;
      live3_q   <= live2_q;
    end
  end

  // Final rounding: the product is rounded to 53 bits, then truncated.
  logic               lead;
  logic [4:0]         dsh;
  logic [83:0]        qs, smask;
  logic               hb, st, up;
  logic [54:0]        rq;
  logic signed [12:0] ish_s;
  logic [31:0]        mag, sv;
  logic [63:0]        ires, fres;
  logic [24:0]        rnd;
  logic [30:0]        fsum;

  always_comb begin
    lead  = (kk == 5'd15) ? q3_q[67] : q3_q[83];
    dsh   = lead ? kk : (kk - 5'd1);
    qs    = q3_q >> dsh;
    hb    = q3_q[dsh - 5'd1];
    smask = (84'(1) << (dsh - 5'd1)) - 84'd1;
    st    = |(q3_q & smask);
    up    = hb & (st | qs[0]);
    rq    = 55'(qs) + 55'(up);
    ish_s = 13'sd52 - e3_q - $signed({8'b0, dsh});
    mag   = 32'(rq >> ish_s[7:0]);
    sv    = sg3_q ? (~mag + 32'd1) : mag;
    if (tiny3_q)             ires = '0;
    else if (ok == FMT_S16)  ires = {48'b0, sv[15:0]};
    else                     ires = {32'b0, sv};
    rnd  = {1'b0, fm3_q} + 25'(fr3_q & (fs3_q | fm3_q[0]));
    fsum = {fbase3_q, 23'b0} + 31'(rnd);
    fres = {32'b0, sg3_q, fsum};
    if (!live3_q)     res_o = '0;
    else if (direct3_q) res_o = dres3_q;
    else if (!ok[1])  res_o = ires;
    else              res_o = fres;
  end

endmodule

`default_nettype wire

// File: tb/pcm_ffr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM frame format remap checker
// Tracks register writes and frame beats on both channels. For every
// accepted input frame it computes the converted frame in its own model of
// the sample converter. It then compares every output frame, lane by lane,
// with the oldest frame still owed.
// ----------------------------------------------------------------------------
module pcm_ffr_checker
  import pcm_ffr_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_idx_i,
  input  wire logic [31:0]      cfg_data_i,
  input  wire logic             in_valid_i,
  input  wire logic             in_ready_i,
  input  wire logic [7:0][63:0] in_words_i,
  input  wire logic             in_last_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_ready_i,
  input  wire logic [7:0][63:0] out_words_i,
  input  wire logic             out_last_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    frames_out_o
);

  typedef struct packed {
    logic [7:0][63:0] words;
    logic             last;
  } frame_t;

  frame_t     owed_frames[$];
  logic [2:0] in_fmt, out_fmt;
  logic [3:0] in_cnt, out_cnt;
  logic [31:0] remap;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    frames_out_o = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count_o++;
  endtask

  // Single precision bits to a real; the value is exact in double precision.
  function automatic real f32_to_real(input logic [31:0] b);
    real    r;
    longint m;
    int     e;
    if (b[30:23] == 8'hFF) return $bitstoreal({b[31], 11'h7FF, 52'b0});
    m = (b[30:23] != 0) ? longint'({1'b1, b[22:0]}) : longint'(b[22:0]);
    e = (b[30:23] != 0) ? int'(b[30:23]) : 1;
    r = real'(m) * (2.0 ** (e - 150));
    return b[31] ? -r : r;
  endfunction

  // Round a real in [-1, 1] to single precision, to nearest even.
  function automatic logic [31:0] real_to_f32(input real s);
    logic [63:0] bits, sig, kept, rest, halfway, mag;
    int          ex, sh;
    bits = $realtobits(s);
    if (bits[62:52] == 0) return {bits[63], 31'b0};
    ex  = int'(bits[62:52]) - 1023;
    sig = {11'b0, 1'b1, bits[51:0]};
    sh  = (ex >= -126) ? 29 : 29 + (-126 - ex);
    if (sh >= 60) return {bits[63], 31'b0};
    kept    = sig >> sh;
    rest    = sig & ((64'd1 << sh) - 1);
    halfway = 64'd1 << (sh - 1);
    if (rest > halfway || (rest == halfway && kept[0])) kept++;
    // A carry out of the mantissa moves into the exponent by itself.
    mag = (ex >= -126) ? ((64'(ex + 126) << 23) + kept) : kept;
    return {bits[63], mag[30:0]};
  endfunction

  function automatic logic [63:0] convert_sample(input logic [2:0] ifmt,
                                                 input logic [2:0] ofmt,
                                                 input logic [63:0] raw);
    logic [1:0]  ik, ok;
    logic        is_nan, sgn;
    logic [51:0] mant;
    real         s;
    longint      iv;
    ik = ifmt[1:0];
    ok = ofmt[1:0];
    if (ifmt == ofmt) begin
      case (ik)
        FMT_S16: return {48'b0, raw[15:0]};
        FMT_S32, FMT_F32: return {32'b0, raw[31:0]};
        default: return raw;
      endcase
    end
    is_nan = (ik == FMT_F32 && raw[30:23] == 8'hFF && raw[22:0] != 0) ||
             (ik == FMT_F64 && raw[62:52] == 11'h7FF && raw[51:0] != 0);
    if (is_nan) begin
      if (ok == FMT_S16 || ok == FMT_S32) return 64'b0;
      if (ik == FMT_F32) begin
        sgn  = raw[31];
        mant = {raw[22:0], 29'b0};
      end else begin
        sgn  = raw[63];
        mant = raw[51:0];
      end
      if (!(ik == FMT_F64 && ok == FMT_F64)) mant[51] = 1'b1;
      if (ok == FMT_F32) return {32'b0, sgn, 8'hFF, mant[51:29]};
      return {sgn, 11'h7FF, mant};
    end
    case (ik)
      FMT_S16: begin
        iv = longint'($signed(raw[15:0]));
        s  = real'(iv) / 32768.0;
      end
      FMT_S32: begin
        iv = longint'($signed(raw[31:0]));
        s  = real'(iv) / 2147483648.0;
      end
      FMT_F32: s = f32_to_real(raw[31:0]);
      default: s = $bitstoreal(raw);
    endcase
    if (s > 1.0) s = 1.0;
    if (s < -1.0) s = -1.0;
    case (ok)
      FMT_S16: begin
        iv = longint'($rtoi(s * 32767.0));
        return {48'b0, iv[15:0]};
      end
      FMT_S32: begin
        iv = longint'($rtoi(s * 2147483647.0));
        return {32'b0, iv[31:0]};
      end
      FMT_F32: return {32'b0, real_to_f32(s)};
      default: return $realtobits(s);
    endcase
  endfunction

  function automatic frame_t remap_frame(input logic [7:0][63:0] words, input logic last);
    frame_t     f;
    logic [3:0] src;
    f.last = last;
    for (int k = 0; k < 8; k++) begin
      src = remap[4*k +: 4];
      f.words[k] = 64'b0;
      if (k < out_cnt && src < 8 && src < in_cnt)
        f.words[k] = convert_sample(in_fmt, out_fmt, words[src]);
    end
    return f;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_t owed;
    if (!rst_ni) begin
      in_fmt  = {1'b0, FMT_S16};
      out_fmt = {1'b0, FMT_S16};
      in_cnt  = 4'd2;
      out_cnt = 4'd2;
      remap   = 32'h7654_3210;
      owed_frames.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IN_FMT:  in_fmt  = cfg_data_i[2:0];
          REG_OUT_FMT: out_fmt = cfg_data_i[2:0];
          REG_IN_CNT:  in_cnt  = cfg_data_i[3:0];
          REG_OUT_CNT: out_cnt = cfg_data_i[3:0];
          REG_REMAP:   remap   = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        frames_out_o++;
        if (owed_frames.size() == 0) begin
          report_mismatch("output frame with no frame owed");
        end else begin
          owed = owed_frames.pop_front();
          for (int k = 0; k < 8; k++)
            if (out_words_i[k] !== owed.words[k])
              report_mismatch($sformatf("frame %0d lane %0d: got %h, wanted %h",
                              frames_out_o, k, out_words_i[k], owed.words[k]));
          if (out_last_i !== owed.last)
            report_mismatch($sformatf("frame %0d last mark: got %b, wanted %b",
                            frames_out_o, out_last_i, owed.last));
        end
      end
      if (in_valid_i && in_ready_i) owed_frames.push_back(remap_frame(in_words_i, in_last_i));
      pending_o = owed_frames.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM frame format remap testbench
// Drives audio frames through the format converter under many register
// settings, with random gaps on both channels, a long output stall and
// drain pauses. A separate checker predicts and compares every output frame.
// ----------------------------------------------------------------------------
module testbench;
  import pcm_ffr_pkg::*;

  localparam int NUM_PHASES     = 40;
  localparam int FRAMES_PER_RUN = 32;
  localparam int IDLE_LIMIT     = 2000;

  logic        clk_i, rst_ni;
  logic        cfg_we, in_valid, in_last, out_ready;
  logic [2:0]  cfg_idx;
  logic [31:0] cfg_data;
  logic [7:0][63:0] in_words, out_words;
  logic        in_ready, out_valid, out_last;
  int          fail_count, pending, frames_out, frames_in, settings_used;
  logic        no_idle, hold_req;
  int          hold_cnt, stall_cnt, idle_cycles;

  pcm_frame_format_remap DUT (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_ch0_i(in_words[0]), .in_ch1_i(in_words[1]), .in_ch2_i(in_words[2]),
    .in_ch3_i(in_words[3]), .in_ch4_i(in_words[4]), .in_ch5_i(in_words[5]),
    .in_ch6_i(in_words[6]), .in_ch7_i(in_words[7]), .in_last_i(in_last),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_ch0_o(out_words[0]), .out_ch1_o(out_words[1]), .out_ch2_o(out_words[2]),
    .out_ch3_o(out_words[3]), .out_ch4_o(out_words[4]), .out_ch5_o(out_words[5]),
    .out_ch6_o(out_words[6]), .out_ch7_o(out_words[7]), .out_last_o(out_last)
  );

  pcm_ffr_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_words_i(in_words),
    .in_last_i(in_last),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_words_i(out_words),
    .out_last_i(out_last),
    .fail_count_o(fail_count), .pending_o(pending), .frames_out_o(frames_out)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Boundary and special values of each sample kind.
  function automatic logic [63:0] special_word(input logic [1:0] kind, input int k);
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    case (kind)
      FMT_S16: case (k)
        0: return 64'h0000; 1: return 64'h7FFF; 2: return 64'h8000; 3: return 64'hFFFF;
        4: return 64'h0001; 5: return 64'h4000; 6: return 64'hC000;
        default: return {48'b0, rnd[15:0]};
      endcase
      FMT_S32: case (k)
        0: return 64'h0; 1: return 64'h7FFF_FFFF; 2: return 64'h8000_0000;
        3: return 64'hFFFF_FFFF; 4: return 64'h1; 5: return 64'h4000_0000;
        6: return 64'hC000_0000;
        default: return {32'b0, rnd[31:0]};
      endcase
      FMT_F32: case (k)
        0: return 64'h0; 1: return 64'h8000_0000; 2: return 64'h3F80_0000;
        3: return 64'hBF80_0000; 4: return 64'h7F80_0000; 5: return 64'hFF80_0000;
        6: return {32'b0, rnd[31], 8'hFF, rnd[22:1], 1'b1};
        default: return {32'b0, rnd[31], 8'($urandom_range(0, 128)), rnd[22:0]};
      endcase
      default: case (k)
        0: return 64'h0; 1: return 64'h8000_0000_0000_0000;
        2: return 64'h3FF0_0000_0000_0000; 3: return 64'hBFF0_0000_0000_0000;
        4: return 64'h7FF0_0000_0000_0000; 5: return 64'hFFF0_0000_0000_0000;
        6: return {rnd[63], 11'h7FF, rnd[51:1], 1'b1};
        default: return {rnd[63], 11'($urandom_range(0, 1024)), rnd[51:0]};
      endcase
    endcase
  endfunction

  // A sample for the given input format; garbage is kept in the unused bits.
  function automatic logic [63:0] pick_sample(input logic [2:0] fmt);
    logic [63:0] rnd, sp;
    rnd = {$urandom, $urandom};
    if ($urandom_range(0, 9) < 4) return rnd;
    sp = special_word(fmt[1:0], $urandom_range(0, 7));
    case (fmt[1:0])
      FMT_S16: return {rnd[63:16], sp[15:0]};
      FMT_S32, FMT_F32: return {rnd[63:32], sp[31:0]};
      default: return sp;
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [2:0] ifmt, input logic [2:0] ofmt,
                               input logic [3:0] icnt, input logic [3:0] ocnt,
                               input logic [31:0] map);
    write_reg(REG_IN_FMT, 32'(ifmt));
    write_reg(REG_OUT_FMT, 32'(ofmt));
    write_reg(REG_IN_CNT, 32'(icnt));
    write_reg(REG_OUT_CNT, 32'(ocnt));
    write_reg(REG_REMAP, map);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_frame(input logic [7:0][63:0] words, input logic last);
    int gap;
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_words <= words;
    in_last  <= last;
    do @(posedge clk_i); while (!in_ready);
    frames_in++;
  endtask

  // Sender pause: every owed frame comes out, then the lanes settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // Output side: random stalls, plus one long hold on request.
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 79;
        out_ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 4) == 0) stall_cnt = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no beat for %0d cycles, %0d frames owed", IDLE_LIMIT, pending);
      $display("[pcm_frame_format_remap] ERROR");
      $finish;
    end
  end

  initial begin
    logic [2:0]  d_if[12]  = '{3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd3,
                               3'd3, 3'd1, 3'd4, 3'd5, 3'd6, 3'd7};
    logic [2:0]  d_of[12]  = '{3'd0, 3'd2, 3'd3, 3'd2, 3'd6, 3'd7,
                               3'd1, 3'd0, 3'd4, 3'd5, 3'd6, 3'd7};
    logic [3:0]  d_ic[12]  = '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
                               4'd8, 4'd1, 4'd0, 4'd15, 4'd8, 4'd8};
    logic [3:0]  d_oc[12]  = '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8,
                               4'd8, 4'd8, 4'd15, 4'd0, 4'd1, 4'd8};
    logic [31:0] d_map[12] = '{32'h7654_3210, 32'h7654_3210, 32'h7654_3210,
                               32'h7654_3210, 32'h7654_3210, 32'h7654_3210,
                               32'h7654_3210, 32'h0123_4567, 32'hFFFF_FFFF,
                               32'h0000_0000, 32'h89AB_CDEF, 32'h0000_0000};
    logic [7:0][63:0] words;
    logic [2:0]  ifmt, ofmt;
    logic [3:0]  icnt, ocnt;
    logic [31:0] map;
    rst_ni = 1'b0;
    cfg_we <= 1'b0; cfg_idx <= REG_IN_FMT; cfg_data <= 32'b0;
    in_valid <= 1'b0; in_words <= '0; in_last <= 1'b0;
    no_idle = 1'b0; hold_req = 1'b0; hold_cnt = 0; stall_cnt = 0;
    idle_cycles = 0; frames_in = 0; settings_used = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: special values of every kind through several format pairs,
    // then all ones and all zeros.
    for (int d = 0; d < 12; d++) begin
      load_settings(d_if[d], d_of[d], d_ic[d], d_oc[d], d_map[d]);
      for (int k = 0; k < 8; k++) words[k] = special_word(d_if[d][1:0], k);
      send_frame(words, 1'b0);
      send_frame((d % 2 == 0) ? '1 : '0, (d % 2 == 0));
      drain();
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      ifmt = 3'($urandom_range(0, 7));
      ofmt = ($urandom_range(0, 5) == 0) ? ifmt : 3'($urandom_range(0, 7));
      icnt = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
      ocnt = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
      map  = $urandom;
      if ($urandom_range(0, 2) != 0) map &= 32'h7777_7777;
      if (p == 0) begin
        icnt = 4'd8;
        ocnt = 4'd8;
      end
      load_settings(ifmt, ofmt, icnt, ocnt, map);
      no_idle = (p < 2);
      if (p == 0) hold_req = 1'b1;
      for (int n = 0; n < FRAMES_PER_RUN; n++) begin
        for (int k = 0; k < 8; k++) words[k] = pick_sample(ifmt);
        send_frame(words, 1'($urandom));
      end
      drain();
    end

    $display("Covered %0d frames in and %0d frames out over %0d register settings,",
             frames_in, frames_out, settings_used);
    $display("with every format pair class, silent and unused channels, stalls and drains.");
    if (fail_count == 0) begin
      $display("[pcm_frame_format_remap] OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("[pcm_frame_format_remap] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/pcm_ffr_pkg.sv
sv/pcm_ffr_lane.sv
sv/pcm_frame_format_remap.sv
tb/pcm_ffr_checker.sv
tb/testbench.sv
